FILE: rtl/assert_macros.svh
// Assertion helpers; clk and rst must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IAA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define IAA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define IAA_ASSERT(lbl, expr)
`define IAA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/iaa_pkg.sv
package iaa_pkg;

  localparam int IAA_WINDOW_MINUTES = 16;

  localparam int SAMPLE_W = 13;
  localparam int MINUTE_W = 32;
  localparam int COUNT_W  = 8;
  localparam int THRESH_W = 24;

  // request kinds carried in s_tuser[0]
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ALERT_MINUTES  = 2'd0;
  localparam logic [1:0] REG_REPEAT_MINUTES = 2'd1;
  localparam logic [1:0] REG_THRESHOLD      = 2'd2;

  localparam logic [COUNT_W-1:0]  ALERT_RESET     = 8'd60;
  localparam logic [COUNT_W-1:0]  REPEAT_RESET    = 8'd60;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 24'd1000000;

  typedef logic [MINUTE_W-1:0] minute_t;

endpackage

FILE: rtl/iaa_cell.sv
module iaa_cell
  import iaa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    shift,
  input  minute_t din,
  output minute_t dout
);

  minute_t value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

FILE: rtl/iaa_window.sv
module iaa_window
  import iaa_pkg::*;
#(
  parameter int WINDOW_MINUTES = IAA_WINDOW_MINUTES,
  localparam int TOTAL_W = MINUTE_W + $clog2(WINDOW_MINUTES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  minute_t            minute_in,
  output logic [TOTAL_W-1:0] total_next
);

  minute_t             link [WINDOW_MINUTES+1];
  logic [TOTAL_W-1:0]  total;

  assign link[0] = minute_in;

  // newest minute enters cell 0, oldest falls out of the last cell
  for (genvar i = 0; i < WINDOW_MINUTES; i++) begin : g_cell
    iaa_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign total_next = total - TOTAL_W'(link[WINDOW_MINUTES]) + TOTAL_W'(minute_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (shift) begin
      total <= total_next;
    end
  end

endmodule

FILE: rtl/accel_inactivity_alert.sv
// channel   dir  tdata                              tuser
// s_*       in   accel_x, accel_y, accel_z (40b)    req_type, first_of_batch
// m_*       out  alert_pulse, inactive_shown,       -
//                minutes_inactive (16b)
// apb       in   alert_minutes, repeat_minutes, active_level at 0x0/0x4/0x8
//
// One item per cycle unless the output stalls; its result is registered and shows in the cycle after accept.
// The whole update (window shift, running sum, compare, count) closes in the accept cycle.
// s_tready drops only while a result sits in the output register and m_tready is low.
// rst is synchronous: window cells, sums, counts and registers return to defaults.
module accel_inactivity_alert
  import iaa_pkg::*;
#(
  parameter int WINDOW_MINUTES = IAA_WINDOW_MINUTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // accel_x[12:0], accel_y[25:13], accel_z[38:26], 0
  input  logic [1:0]  s_tuser,  // req_type[0], first_of_batch[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // alert_pulse[0], inactive_shown[1],
                                // minutes_inactive[9:2], 0
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  localparam int TOTAL_W = MINUTE_W + $clog2(WINDOW_MINUTES + 1);
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int ADD_W   = SAMPLE_W + 2;

  logic [COUNT_W-1:0]  alert_minutes;
  logic [COUNT_W-1:0]  repeat_minutes;
  logic [THRESH_W-1:0] active_level;

  logic signed [SAMPLE_W-1:0] prev [3];
  logic signed [SAMPLE_W-1:0] smp  [3];
  minute_t                    minute_total;
  minute_t                    minute_total_next;
  logic [COUNT_W-1:0]         inactive_count;
  logic [COUNT_W-1:0]         inactive_count_next;
  logic                       shown_flag;
  logic                       shown_flag_next;
  logic                       pulse_next;

  logic               accept;
  logic               is_tick;
  logic [TOTAL_W-1:0] total_next;
  logic [DIFF_W-1:0]  diff [3];
  logic [ADD_W-1:0]   add;
  logic [MINUTE_W:0]  sum_wide;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] rep;
  logic               wr_en;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alert_minutes  <= ALERT_RESET;
      repeat_minutes <= REPEAT_RESET;
      active_level   <= THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ALERT_MINUTES:  alert_minutes  <= pwdata[COUNT_W-1:0];
        REG_REPEAT_MINUTES: repeat_minutes <= pwdata[COUNT_W-1:0];
        REG_THRESHOLD:      active_level   <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ALERT_MINUTES:  prdata = 32'(alert_minutes);
      REG_REPEAT_MINUTES: prdata = 32'(repeat_minutes);
      REG_THRESHOLD:      prdata = 32'(active_level);
      default:            prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_tick  = (s_tuser[0] == REQ_TICK);

  assign smp[0] = s_tdata[12:0];
  assign smp[1] = s_tdata[25:13];
  assign smp[2] = s_tdata[38:26];

  // ---------------- motion accumulation ----------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_W'(smp[i]) - DIFF_W'(prev[i]);
      if (diff[i][DIFF_W-1]) begin
        diff[i] = -diff[i];
      end
    end
    add = ADD_W'(diff[0][SAMPLE_W-1:0]) + ADD_W'(diff[1][SAMPLE_W-1:0])
        + ADD_W'(diff[2][SAMPLE_W-1:0]);
    sum_wide = {1'b0, minute_total} + (MINUTE_W+1)'(add);
  end

  // ---------------- activity window ----------------
  iaa_window #(
    .WINDOW_MINUTES(WINDOW_MINUTES)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (accept && is_tick),
    .minute_in (minute_total),
    .total_next(total_next)
  );

  // ---------------- inactivity count ----------------
  always_comb begin
    minute_total_next   = minute_total;
    inactive_count_next = inactive_count;
    shown_flag_next     = shown_flag;
    pulse_next          = 1'b0;
    count_inc = (inactive_count == '1) ? inactive_count : inactive_count + 1'b1;
    rep = (repeat_minutes < alert_minutes) ? repeat_minutes : alert_minutes;
    if (!is_tick) begin
      if (!s_tuser[1]) begin
        minute_total_next = sum_wide[MINUTE_W] ? '1 : sum_wide[MINUTE_W-1:0];
      end
    end else begin
      minute_total_next = '0;
      if (total_next >= TOTAL_W'(active_level)) begin
        inactive_count_next = '0;
        shown_flag_next     = 1'b0;
      end else begin
        inactive_count_next = count_inc;
        if (alert_minutes != '0 && count_inc >= alert_minutes) begin
          pulse_next          = 1'b1;
          inactive_count_next = alert_minutes - rep;
          shown_flag_next     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev[0]        <= '0;
      prev[1]        <= '0;
      prev[2]        <= '0;
      minute_total   <= '0;
      inactive_count <= '0;
      shown_flag     <= 1'b0;
    end else if (accept) begin
      if (!is_tick) begin
        prev[0] <= smp[0];
        prev[1] <= smp[1];
        prev[2] <= smp[2];
      end
      minute_total   <= minute_total_next;
      inactive_count <= inactive_count_next;
      shown_flag     <= shown_flag_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'b0, inactive_count_next, shown_flag_next, pulse_next};
    end
  end

  `IAA_ASSERT(a_pulse_shown, !(m_tvalid && m_tdata[0]) || m_tdata[1])
  `IAA_ASSERT_NEXT(a_accept_valid, accept, m_tvalid)
  `IAA_ASSERT_NEXT(a_tick_clears_minute, accept && is_tick, minute_total == '0)
  `IAA_ASSERT_NEXT(a_sample_keeps_count, accept && !is_tick, inactive_count == $past(inactive_count) && !m_tdata[0])

endmodule
